// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the record sorter.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// cond must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== design/rcs_pkg.sv =====
// ---------------------------------------------------------------------------
// rcs_pkg
// Types, constants and the record order shared by the record sorter.
// ---------------------------------------------------------------------------
package rcs_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // packed so that name_key sits in the lowest bits
    typedef struct packed {
        logic [15:0] year;
        logic [63:0] nation_key;
        logic [63:0] name_key;
    } record_t;

    localparam int REC_W = $bits(record_t);

    typedef struct packed {
        logic    keep;
        logic    last;
        record_t rec;
    } qent_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SRD,
        ST_SEX,
        ST_SWR,
        ST_ORD,
        ST_OPUT
    } state_t;

    typedef enum logic {
        DIR_FWD,
        DIR_BWD
    } dir_t;

    // true when record a must come after record b
    function automatic logic rec_after(record_t a, record_t b);
        logic res;
        if (a.name_key != b.name_key) begin
            res = a.name_key > b.name_key;
        end else if (a.nation_key != b.nation_key) begin
            res = a.nation_key > b.nation_key;
        end else begin
            res = $signed(a.year) > $signed(b.year);
        end
        return res;
    endfunction

endpackage

// ===== design/rcs_fifo.sv =====
// ---------------------------------------------------------------------------
// rcs_fifo
// Short queue between the classifying front end and the sort engine.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rcs_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_i,
    input  rcs_pkg::qent_t ent_i,
    input  logic           pop_i,
    output rcs_pkg::qent_t ent_o,
    output rcs_pkg::qstat_t stat_o
);
    import rcs_pkg::*;

    qent_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wptr_reg, wptr_next;
    logic [QPTR_W-1:0]  rptr_reg, rptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    always_comb begin
        wptr_next = push_i ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next = pop_i ? rptr_reg + QPTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            mem_reg[wptr_reg] <= ent_i;
        end
    end

    assign ent_o        = mem_reg[rptr_reg];
    assign stat_o.empty = (cnt_reg == '0);
    assign stat_o.full  = (cnt_reg == QCNT_W'(QDEPTH));

    `ASSERT_NEVER(a_no_overflow, aclk, aresetn, push_i && stat_o.full, "queue push while full")
    `ASSERT_NEVER(a_no_underflow, aclk, aresetn, pop_i && stat_o.empty, "queue pop while empty")
    `ASSERT_NEVER(a_cnt_range, aclk, aresetn, cnt_reg > QCNT_W'(QDEPTH), "queue count past depth")

endmodule

// ===== design/rcs_front.sv =====
// ---------------------------------------------------------------------------
// rcs_front
// Accept input records, tag them as stored or dropped, queue the survivors.
// ---------------------------------------------------------------------------
module rcs_front #(
    parameter int DEPTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [rcs_pkg::REC_W-1:0]  s_tdata,
    input  logic                       s_tlast,
    input  rcs_pkg::qstat_t            q_stat_i,
    output logic                       q_push_o,
    output rcs_pkg::qent_t             q_ent_o
);
    import rcs_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             xfer;
    logic             keep;

    assign s_tready = !q_stat_i.full;
    assign xfer     = s_tvalid && s_tready;
    assign keep     = (count_reg < CNT_W'(DEPTH));

    // drop a record past DEPTH unless it closes the set
    assign q_push_o     = xfer && (keep || s_tlast);
    assign q_ent_o.keep = keep;
    assign q_ent_o.last = s_tlast;
    assign q_ent_o.rec  = record_t'(s_tdata);

    always_comb begin
        count_next = count_reg;
        if (xfer) begin
            if (s_tlast) begin
                count_next = '0;
            end else if (keep) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/rcs_back.sv =====
// ---------------------------------------------------------------------------
// rcs_back
// Record store, cocktail shaker sort sequencer and sorted output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rcs_back #(
    parameter int DEPTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rcs_pkg::qent_t             q_ent_i,
    input  rcs_pkg::qstat_t            q_stat_i,
    output logic                       q_pop_o,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [rcs_pkg::REC_W-1:0]  m_tdata,
    output logic                       m_tlast
);
    import rcs_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  lo_reg, lo_next;
    logic [IDX_W-1:0]  hi_reg, hi_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  oidx_reg, oidx_next;
    dir_t              dir_reg, dir_next;
    logic              first_reg, first_next;
    logic              moved_reg, moved_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg, out_last_next;
    record_t           out_reg, out_next;
    record_t           carry_reg, carry_next;
    record_t           rd_data_reg;
    record_t           mem [DEPTH];

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    record_t           wr_data;
    logic [IDX_W-1:0]  rd_addr;

    logic              swap;
    logic              pass_end;
    logic              round_again;
    logic              out_load;
    logic              out_final;

    assign swap = (dir_reg == DIR_FWD) ? rec_after(carry_reg, rd_data_reg)
                                       : rec_after(rd_data_reg, carry_reg);
    assign pass_end    = (dir_reg == DIR_FWD) ? (idx_reg == hi_reg) : (idx_reg == lo_reg);
    assign round_again = moved_reg &&
                         (({1'b0, lo_reg} + (IDX_W + 1)'(1)) < {1'b0, hi_reg});
    assign out_load    = !out_valid_reg || m_tready;
    assign out_final   = ((CNT_W'(oidx_reg) + CNT_W'(1)) == count_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat_i.empty && q_ent_i.last) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (count_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (count_reg < CNT_W'(2)) begin
                    state_next = ST_ORD;
                end else begin
                    state_next = ST_SRD;
                end
            end
            ST_SRD: state_next = ST_SEX;
            ST_SEX: state_next = pass_end ? ST_SWR : ST_SRD;
            ST_SWR: begin
                if (dir_reg == DIR_FWD || round_again) begin
                    state_next = ST_SRD;
                end else begin
                    state_next = ST_ORD;
                end
            end
            ST_ORD: state_next = ST_OPUT;
            ST_OPUT: begin
                if (out_load) begin
                    state_next = out_final ? ST_IDLE : ST_ORD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        oidx_next      = oidx_reg;
        dir_next       = dir_reg;
        first_next     = first_reg;
        moved_next     = moved_reg;
        carry_next     = carry_reg;
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = carry_reg;
        rd_addr        = idx_reg;
        q_pop_o        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat_i.empty) begin
                    q_pop_o = 1'b1;
                    if (q_ent_i.keep) begin
                        wr_en      = 1'b1;
                        wr_addr    = IDX_W'(count_reg);
                        wr_data    = q_ent_i.rec;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_PREP: begin
                lo_next    = '0;
                hi_next    = IDX_W'(count_reg - CNT_W'(1));
                idx_next   = '0;
                oidx_next  = '0;
                dir_next   = DIR_FWD;
                first_next = 1'b1;
                moved_next = 1'b0;
            end
            ST_SRD: begin
                rd_addr = idx_reg;
            end
            ST_SEX: begin
                if (first_reg) begin
                    carry_next = rd_data_reg;
                    first_next = 1'b0;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = (dir_reg == DIR_FWD) ? idx_reg - IDX_W'(1)
                                                      : idx_reg + IDX_W'(1);
                    wr_data    = swap ? rd_data_reg : carry_reg;
                    carry_next = swap ? carry_reg : rd_data_reg;
                    if (swap) begin
                        moved_next = 1'b1;
                    end
                end
                if (!pass_end) begin
                    idx_next = (dir_reg == DIR_FWD) ? idx_reg + IDX_W'(1)
                                                    : idx_reg - IDX_W'(1);
                end
            end
            ST_SWR: begin
                wr_en   = 1'b1;
                wr_data = carry_reg;
                if (dir_reg == DIR_FWD) begin
                    wr_addr    = hi_reg;
                    hi_next    = hi_reg - IDX_W'(1);
                    idx_next   = hi_reg - IDX_W'(1);
                    dir_next   = DIR_BWD;
                    first_next = 1'b1;
                end else begin
                    wr_addr = lo_reg;
                    lo_next = lo_reg + IDX_W'(1);
                    if (round_again) begin
                        idx_next   = lo_reg + IDX_W'(1);
                        dir_next   = DIR_FWD;
                        first_next = 1'b1;
                        moved_next = 1'b0;
                    end else begin
                        oidx_next = '0;
                    end
                end
            end
            ST_ORD: begin
                rd_addr = oidx_reg;
            end
            ST_OPUT: begin
                rd_addr = oidx_reg;
                if (out_load) begin
                    out_next       = rd_data_reg;
                    out_last_next  = out_final;
                    out_valid_next = 1'b1;
                    if (out_final) begin
                        count_next = '0;
                    end else begin
                        oidx_next = oidx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                q_pop_o = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            idx_reg       <= '0;
            oidx_reg      <= '0;
            dir_reg       <= DIR_FWD;
            first_reg     <= 1'b0;
            moved_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            idx_reg       <= idx_next;
            oidx_reg      <= oidx_next;
            dir_reg       <= dir_next;
            first_reg     <= first_next;
            moved_reg     <= moved_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        carry_reg <= carry_next;
        out_reg   <= out_next;
    end

    // record store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = out_last_reg;

    `ASSERT_NEVER(a_count_range, aclk, aresetn, count_reg > CNT_W'(DEPTH), "record count past depth")
    `ASSERT_AT(a_sort_window, aclk, aresetn, (state_reg == ST_SRD || state_reg == ST_SEX) |-> (idx_reg >= lo_reg && idx_reg <= hi_reg), "sort index outside pass window")
    `ASSERT_AT(a_pop_idle, aclk, aresetn, q_pop_o |-> (state_reg == ST_IDLE), "queue popped while sorting")

endmodule

// ===== design/record_cocktail_sorter_core.sv =====
// Sorting: after the set's last record, cocktail shaker passes run over the n stored records;
//   each compare-swap reads a record in ST_SRD and writes back in ST_SEX on the store port.
// Throughput: records load one per cycle while idle; output reads each record in ST_ORD
//   and loads it in ST_OPUT, and a round of passes that makes no swap ends the sort early.
// Reset: aresetn low clears the queue, counters, sequencer and output valid; store is unset.
// ---------------------------------------------------------------------------
// record_cocktail_sorter_core
// Collects records, sorts them by name, nationality and year, streams them out.
// ---------------------------------------------------------------------------
module record_cocktail_sorter_core #(
    parameter int DEPTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [rcs_pkg::REC_W-1:0]  s_tdata,   // name_key, nation_key, year_value
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [rcs_pkg::REC_W-1:0]  m_tdata,   // out_name_key, out_nation_key, out_year
    output logic                       m_tlast
);
    import rcs_pkg::*;

    logic   q_push;
    logic   q_pop;
    qent_t  q_wr_ent;
    qent_t  q_rd_ent;
    qstat_t q_stat;

    rcs_front #(
        .DEPTH(DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat_i (q_stat),
        .q_push_o (q_push),
        .q_ent_o  (q_wr_ent)
    );

    rcs_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (q_push),
        .ent_i   (q_wr_ent),
        .pop_i   (q_pop),
        .ent_o   (q_rd_ent),
        .stat_o  (q_stat)
    );

    rcs_back #(
        .DEPTH(DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_ent_i  (q_rd_ent),
        .q_stat_i (q_stat),
        .q_pop_o  (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/record_cocktail_sorter_core_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// record_cocktail_sorter_core_test
// Streams sets of name/nationality/year records into the sorter and checks
// each sorted run against an in-bench model: records are kept up to the
// store depth, sorted ascending by name, nationality and signed year when the
// set's final transfer arrives, and expected in order with the final one
// marked. Covers single-record sets, extreme and tied keys, store overflow,
// random sets under bursty input and a stalling receiver, and a long output
// hold-off that backs the sorter up into its input.
// ---------------------------------------------------------------------------
module record_cocktail_sorter_core_test;
    import rcs_pkg::*;

    localparam int STORE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 340;
    localparam int LONG_HOLD    = 3000;
    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE       = 600;

    typedef struct {
        record_t rec;
        bit      last;
    } sorted_rec_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [REC_W-1:0] s_tdata  = '0;   // name_key, nation_key, year_value
    logic             s_tlast  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [REC_W-1:0] m_tdata;         // out_name_key, out_nation_key, out_year
    logic             m_tlast;

    record_t     set_store [STORE_DEPTH];
    int          set_count;
    sorted_rec_t sorted_expect [$];

    logic [63:0] name_pool [4];
    logic [63:0] nation_pool [4];
    logic [15:0] year_pool [4];

    int mismatches;
    int burst_left;
    int idle_cycles;
    int stall_mode;
    int mode_left;
    int hold_left;
    bit hold_req;

    record_cocktail_sorter_core #(.DEPTH(STORE_DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    function automatic bit record_later(record_t a, record_t b);
        if (a.name_key != b.name_key) begin
            return a.name_key > b.name_key;
        end
        if (a.nation_key != b.nation_key) begin
            return a.nation_key > b.nation_key;
        end
        return $signed(a.year) > $signed(b.year);
    endfunction

    // store the record if there is room; on the final one, sort and queue the run
    task automatic absorb_record(input record_t rec, input bit last);
        record_t     run [$];
        record_t     tmp;
        sorted_rec_t item;
        int          j;
        if (set_count < STORE_DEPTH) begin
            set_store[set_count] = rec;
            set_count++;
        end
        if (!last) begin
            return;
        end
        for (int i = 0; i < set_count; i++) begin
            tmp = set_store[i];
            j   = run.size();
            while (j > 0 && record_later(run[j-1], tmp)) begin
                j--;
            end
            run.insert(j, tmp);
        end
        foreach (run[i]) begin
            item.rec  = run[i];
            item.last = (i == run.size() - 1);
            sorted_expect.push_back(item);
        end
        set_count = 0;
    endtask

    task automatic send_record(input record_t rec, input bit last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= rec;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        absorb_record(rec, last);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (sorted_expect.size() != 0) @(posedge aclk);
    endtask

    function automatic record_t make_record(logic [63:0] name, logic [63:0] nation,
                                            logic [15:0] year);
        record_t r;
        r.name_key   = name;
        r.nation_key = nation;
        r.year       = year;
        return r;
    endfunction

    function automatic logic [63:0] random_key64();
        return {$urandom(), $urandom()};
    endfunction

    // pools make ties on one or more keys likely within a set
    task automatic refresh_pools();
        logic [63:0] stem;
        stem = random_key64();
        for (int i = 0; i < 4; i++) begin
            name_pool[i]   = ($urandom_range(0, 1) == 0) ? random_key64()
                                                         : {stem[63:8], 8'(i)};
            nation_pool[i] = random_key64();
        end
        year_pool[0] = 16'h8000;
        year_pool[1] = 16'h7fff;
        year_pool[2] = 16'h0000;
        year_pool[3] = 16'hffff;
    endtask

    function automatic record_t random_record();
        record_t r;
        r.name_key   = ($urandom_range(0, 1) == 0) ? name_pool[$urandom_range(0, 3)]
                                                   : random_key64();
        r.nation_key = ($urandom_range(0, 1) == 0) ? nation_pool[$urandom_range(0, 3)]
                                                   : random_key64();
        r.year       = ($urandom_range(0, 2) == 0) ? year_pool[$urandom_range(0, 3)]
                                                   : 16'($urandom());
        return r;
    endfunction

    task automatic send_random_set(input int n);
        refresh_pools();
        for (int i = 0; i < n; i++) begin
            send_record(random_record(), i == n - 1);
        end
    endtask

    task automatic test_single_record();
        send_record(make_record(64'h4142_4300_0000_0000, 64'h5859_0000_0000_0000,
                                16'h07d0), 1'b1);
        drain_results();
    endtask

    task automatic test_extremes_and_ties();
        send_record(make_record('1, '0, 16'h7fff), 1'b0);
        send_record(make_record('0, '1, 16'h8000), 1'b0);
        send_record(make_record('0, '1, 16'h7fff), 1'b0);
        send_record(make_record('0, '0, 16'hffff), 1'b0);
        send_record(make_record('0, '1, 16'h8000), 1'b0);
        send_record(make_record(64'h8000_0000_0000_0000, 64'h1, 16'h0000), 1'b1);
        drain_results();
    endtask

    // the final transfer lands on a full store: dropped, but still closes the set
    task automatic test_store_overflow();
        refresh_pools();
        for (int i = 0; i <= STORE_DEPTH; i++) begin
            send_record(random_record(), i == STORE_DEPTH);
        end
        drain_results();
    endtask

    task automatic test_random_sets();
        int sent;
        int n;
        int pick;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                n = $urandom_range(1, 12);
            end else if (pick < 18) begin
                n = STORE_DEPTH;
            end else begin
                n = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
            end
            send_random_set(n);
            sent += n;
        end
        drain_results();
    endtask

    task automatic test_output_backpressure();
        hold_req = 1'b1;
        send_random_set(STORE_DEPTH);
        send_random_set(STORE_DEPTH);
        send_random_set(10);
        drain_results();
    endtask

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 150);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 1) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (mismatches < 10) begin
            $display("%0t: %s expected %h, got %h", $realtime, field, want, got);
        end
        mismatches++;
    endtask

    always @(posedge aclk) begin
        record_t     got;
        sorted_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (sorted_expect.size() == 0) begin
                note_mismatch("unexpected transfer, name_key", '0, got.name_key);
            end else begin
                want = sorted_expect.pop_front();
                if (got.name_key != want.rec.name_key) begin
                    note_mismatch("out_name_key", want.rec.name_key, got.name_key);
                end
                if (got.nation_key != want.rec.nation_key) begin
                    note_mismatch("out_nation_key", want.rec.nation_key, got.nation_key);
                end
                if (got.year != want.rec.year) begin
                    note_mismatch("out_year", 64'(want.rec.year), 64'(got.year));
                end
                if (m_tlast !== want.last) begin
                    note_mismatch("out_last", 64'(want.last), 64'(m_tlast));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        mismatches = 0;
        set_count  = 0;
        burst_left = 0;
        stall_mode = 0;
        mode_left  = 0;
        hold_left  = 0;
        hold_req   = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_single_record();
        test_extremes_and_ties();
        test_store_overflow();
        test_random_sets();
        test_output_backpressure();

        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && sorted_expect.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
